// ===== rtl/interval_set_union_subtract_assert.svh =====
// Assertion macros shared by the checker of the interval set block.
// Depends on nothing; included by bare file name.
`ifndef INTERVAL_SET_UNION_SUBTRACT_ASSERT_SVH
`define INTERVAL_SET_UNION_SUBTRACT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define ISU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define ISU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/isu_pkg.sv =====
// Types and constants for the interval set union/subtract block.
// Used by the top level and by its checker.
package isu_pkg;

  typedef enum logic {
    REQ_UNION    = 1'b0,
    REQ_SUBTRACT = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e          req_type;
    logic signed [31:0] span_start;
    logic signed [31:0] span_end;
  } req_t;

  typedef struct packed {
    logic [31:0] covered_length;
    logic [6:0]  entry_count;
    logic        overflow;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

endpackage

// ===== rtl/interval_set_union_subtract.sv =====
// Top level of the disjoint interval set with union and subtract.
// Depends on isu_pkg.
//
// The block holds up to CAPACITY sorted, disjoint half-open intervals in two
// memory banks. A request streams the active bank through one read port, one
// stored interval per cycle except while a pending interval is written, and
// writes the rebuilt table into the other bank; the banks swap when the pass
// ends without overflow, so a rejected request leaves the table untouched.
// The merged or new interval of a union, and the upper piece when a subtract
// splits a stored interval in two, are written in a step of their own; an
// empty interval skips the pass. The table is empty after reset with no
// clearing pass. Each request returns one response with the covered length,
// the interval count and an overflow flag; a response waits in an output
// register while the next request is taken.
module interval_set_union_subtract #(
  parameter int CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  isu_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output isu_pkg::rsp_t out_data_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(CAPACITY + 2);

  isu_pkg::state_e state_q, state_d;

  logic               sel_q, sel_d;
  logic [NW-1:0]      n_q, n_d;
  logic [31:0]        total_q, total_d;
  logic [NW-1:0]      ridx_q, ridx_d;
  logic [CW-1:0]      wcnt_q, wcnt_d;
  logic [31:0]        sum_q, sum_d;
  logic               op_q, op_d;
  logic signed [31:0] s_q, s_d, e_q, e_d;
  logic               pv_q, pv_d;
  logic signed [31:0] ps_q, ps_d, pe_q, pe_d;
  logic               ovf_q, ovf_d;
  logic               out_valid_q, out_valid_d;
  isu_pkg::rsp_t      out_q, out_d;

  logic [63:0]        mem0 [CAPACITY];
  logic [63:0]        mem1 [CAPACITY];
  logic [63:0]        rd0_q, rd1_q;
  logic [NW-1:0]      raddr;
  logic               wr_en;
  logic signed [31:0] ws, we;

  logic signed [31:0] cs, ce;
  logic               cur_valid, is_before, is_after, consume;

  assign cs = $signed(sel_q ? rd1_q[63:32] : rd0_q[63:32]);
  assign ce = $signed(sel_q ? rd1_q[31:0] : rd0_q[31:0]);
  assign cur_valid = (ridx_q < n_q);
  assign is_before = (ce <= s_q);
  assign is_after  = (cs >= e_q);

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    n_d         = n_q;
    total_d     = total_q;
    ridx_d      = ridx_q;
    wcnt_d      = wcnt_q;
    sum_d       = sum_q;
    op_d        = op_q;
    s_d         = s_q;
    e_d         = e_q;
    pv_d        = pv_q;
    ps_d        = ps_q;
    pe_d        = pe_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    wr_en       = 1'b0;
    ws          = ps_q;
    we          = pe_q;
    consume     = 1'b0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      isu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ridx_d     = '0;
        if (in_valid_i) begin
          op_d   = in_data_i.req_type;
          s_d    = in_data_i.span_start;
          e_d    = in_data_i.span_end;
          ps_d   = in_data_i.span_start;
          pe_d   = in_data_i.span_end;
          pv_d   = (in_data_i.req_type == isu_pkg::REQ_UNION);
          wcnt_d = '0;
          sum_d  = '0;
          ovf_d  = 1'b0;
          // An empty interval leaves the table as it is.
          if (in_data_i.span_start < in_data_i.span_end) begin
            state_d = isu_pkg::ST_RUN;
          end else begin
            state_d = isu_pkg::ST_FIN;
          end
        end
      end

      isu_pkg::ST_RUN: begin
        if (pv_q && (!cur_valid || op_q == isu_pkg::REQ_SUBTRACT || is_after)) begin
          // Pending interval goes out ahead of the current stored one, or after the last.
          wr_en = 1'b1;
          pv_d  = 1'b0;
        end else if (cur_valid) begin
          consume = 1'b1;
          ridx_d  = ridx_q + NW'(1);
          if (is_before || is_after) begin
            wr_en = 1'b1;
            ws    = cs;
            we    = ce;
          end else if (op_q == isu_pkg::REQ_UNION) begin
            ps_d = (cs < ps_q) ? cs : ps_q;
            pe_d = (ce > pe_q) ? ce : pe_q;
          end else if (cs < s_q) begin
            wr_en = 1'b1;
            ws    = cs;
            we    = s_q;
            if (ce > e_q) begin
              pv_d = 1'b1;
              ps_d = e_q;
              pe_d = ce;
            end
          end else if (ce > e_q) begin
            wr_en = 1'b1;
            ws    = e_q;
            we    = ce;
          end
        end else begin
          if (wcnt_q > CW'(CAPACITY)) begin
            ovf_d = 1'b1;
          end else begin
            sel_d   = ~sel_q;
            n_d     = NW'(wcnt_q);
            total_d = sum_q;
          end
          state_d = isu_pkg::ST_FIN;
        end
        if (wr_en) begin
          wcnt_d = wcnt_q + CW'(1);
          sum_d  = sum_q + 32'(we - ws);
        end
      end

      isu_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.covered_length = total_q;
          out_d.entry_count    = 7'(n_q);
          out_d.overflow       = ovf_q;
          state_d              = isu_pkg::ST_IDLE;
        end
      end

      default: state_d = isu_pkg::ST_IDLE;
    endcase
  end

  assign raddr = consume ? (ridx_q + NW'(1)) : ridx_d;

  always_ff @(posedge clk_i) begin
    rd0_q <= mem0[raddr[AW-1:0]];
    if (wr_en && sel_q && wcnt_q < CW'(CAPACITY)) begin
      mem0[wcnt_q[AW-1:0]] <= {ws, we};
    end
  end

  always_ff @(posedge clk_i) begin
    rd1_q <= mem1[raddr[AW-1:0]];
    if (wr_en && !sel_q && wcnt_q < CW'(CAPACITY)) begin
      mem1[wcnt_q[AW-1:0]] <= {ws, we};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isu_pkg::ST_IDLE;
      sel_q       <= 1'b0;
      n_q         <= '0;
      total_q     <= '0;
      ridx_q      <= '0;
      wcnt_q      <= '0;
      pv_q        <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      n_q         <= n_d;
      total_q     <= total_d;
      ridx_q      <= ridx_d;
      wcnt_q      <= wcnt_d;
      pv_q        <= pv_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    op_q  <= op_d;
    s_q   <= s_d;
    e_q   <= e_d;
    ps_q  <= ps_d;
    pe_q  <= pe_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/isu_checker.sv =====
// Port-level checker for the interval set block, bound to the top level.
// Depends on isu_pkg and interval_set_union_subtract_assert.svh.
`include "interval_set_union_subtract_assert.svh"

module isu_checker #(
  parameter int CAPACITY = 64
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input isu_pkg::rsp_t out_data_o
);

  // A response stays offered, unchanged, until it is taken.
  `ISU_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "response dropped or changed while stalled")

  // A rejected request only happens with a full table.
  `ISU_ASSERT(a_ovf_full, clk_i, rst_ni, out_valid_o && out_data_o.overflow |-> out_data_o.entry_count == 7'(CAPACITY), "overflow reported with room left")

  // The count never exceeds the capacity when it fits in the field.
  `ISU_ASSERT(a_count_cap, clk_i, rst_ni, out_valid_o && CAPACITY < 128 |-> out_data_o.entry_count <= 7'(CAPACITY), "interval count above capacity")

  // Once reset has been seen at a clock edge, no response is offered.
  `ISU_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o, "response offered after reset")

endmodule

bind interval_set_union_subtract isu_checker #(.CAPACITY(CAPACITY)) u_isu_checker (.*);
